@@ rtl/varint_length_packet_deframer_core_macros.svh @@
// assertion macros shared by the deframer rtl
`ifndef VARINT_LENGTH_PACKET_DEFRAMER_CORE_MACROS_SVH
`define VARINT_LENGTH_PACKET_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, clocked on clock, quiet during reset
`define VLPD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, quiet during reset
`define VLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/vlpd_pkg.sv @@
// types and constants of the varint length packet deframer
package vlpd_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] MAX_GROUPS = 3'd5;

   typedef enum logic [1:0] {
      PHASE_LEN  = 2'd0,
      PHASE_DLEN = 2'd1,
      PHASE_PAY  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD     = 3'd0,
      KIND_EMPTY       = 3'd1,
      KIND_PREFIX_LONG = 3'd2,
      KIND_NEGATIVE    = 3'd3,
      KIND_DLEN_LONG   = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         data_byte;
      logic               first;
      logic               last;
      logic signed [31:0] data_length;
   } result_type;

   typedef struct packed {
      logic       write_en;
      result_type entry;
   } push_type;

   typedef struct packed {
      logic       full;
      logic       not_empty;
      result_type head;
   } queue_status_type;

endpackage

@@ rtl/vlpd_decoder.sv @@
// front end: varint prefix decode, packet framing, a byte per cycle unless full
`include "varint_length_packet_deframer_core_macros.svh"

module vlpd_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_in_byte,
   input  logic                  queue_full,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   output vlpd_pkg::push_type    push
);

   logic                 compression_on_ff;
   vlpd_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           group_count_ff, group_count_in;
   logic [31:0]          length_accum_ff, length_accum_in;
   logic [30:0]          bytes_left_ff, bytes_left_in;
   logic [31:0]          data_len_accum_ff, data_len_accum_in;
   logic                 first_pending_ff, first_pending_in;

   logic        accept;
   logic [6:0]  grp;
   logic        cont;
   logic [31:0] placed;
   logic [31:0] len_acc_next;
   logic [31:0] dla_next;
   logic [2:0]  gc_inc;
   logic [30:0] bl_dec;

   function automatic logic [31:0] place_group(input logic [6:0] g, input logic [2:0] n);
      logic [31:0] r;
      case (n)
         3'd0:    r = {25'd0, g};
         3'd1:    r = {18'd0, g, 7'd0};
         3'd2:    r = {11'd0, g, 14'd0};
         3'd3:    r = {4'd0, g, 21'd0};
         3'd4:    r = {g[3:0], 28'd0};
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   assign accept       = req_valid && !queue_full;
   assign grp          = req_in_byte[6:0];
   assign cont         = req_in_byte[7];
   assign placed       = place_group(grp, group_count_ff);
   assign len_acc_next = length_accum_ff | placed;
   assign dla_next     = data_len_accum_ff | placed;
   assign gc_inc       = group_count_ff + 3'd1;
   assign bl_dec       = bytes_left_ff - 31'd1;

   // next state
   always_comb begin
      phase_in          = phase_ff;
      group_count_in    = group_count_ff;
      length_accum_in   = length_accum_ff;
      bytes_left_in     = bytes_left_ff;
      data_len_accum_in = data_len_accum_ff;
      first_pending_in  = first_pending_ff;
      if (accept) begin
         case (phase_ff)
            vlpd_pkg::PHASE_DLEN: begin
               group_count_in    = gc_inc;
               bytes_left_in     = bl_dec;
               data_len_accum_in = dla_next;
               if ((cont && gc_inc >= vlpd_pkg::MAX_GROUPS) || (!cont && bl_dec == 31'd0)
                   || (cont && bl_dec == 31'd0)) begin
                  // error or packet used up by the data-length field: start over
                  phase_in          = vlpd_pkg::PHASE_LEN;
                  group_count_in    = 3'd0;
                  length_accum_in   = 32'd0;
                  bytes_left_in     = 31'd0;
                  data_len_accum_in = 32'd0;
                  first_pending_in  = 1'b1;
               end else if (!cont) begin
                  group_count_in = 3'd0;
                  phase_in       = vlpd_pkg::PHASE_PAY;
               end
            end
            vlpd_pkg::PHASE_PAY: begin
               first_pending_in = 1'b0;
               bytes_left_in    = bl_dec;
               if (bl_dec == 31'd0) begin
                  phase_in          = vlpd_pkg::PHASE_LEN;
                  group_count_in    = 3'd0;
                  length_accum_in   = 32'd0;
                  data_len_accum_in = 32'd0;
                  first_pending_in  = 1'b1;
               end
            end
            default: begin
               phase_in = vlpd_pkg::PHASE_LEN;
               if (group_count_ff >= vlpd_pkg::MAX_GROUPS || (!cont && len_acc_next[31])
                   || (!cont && len_acc_next[30:0] == 31'd0)) begin
                  group_count_in    = 3'd0;
                  length_accum_in   = 32'd0;
                  bytes_left_in     = 31'd0;
                  data_len_accum_in = 32'd0;
                  first_pending_in  = 1'b1;
               end else if (cont) begin
                  length_accum_in = len_acc_next;
                  group_count_in  = gc_inc;
               end else begin
                  group_count_in    = 3'd0;
                  bytes_left_in     = len_acc_next[30:0];
                  length_accum_in   = 32'd0;
                  data_len_accum_in = 32'd0;
                  first_pending_in  = 1'b1;
                  phase_in = compression_on_ff ? vlpd_pkg::PHASE_DLEN : vlpd_pkg::PHASE_PAY;
               end
            end
         endcase
      end
   end

   // result formation
   always_comb begin
      push.write_en          = 1'b0;
      push.entry.kind        = vlpd_pkg::KIND_PAYLOAD;
      push.entry.data_byte   = 8'd0;
      push.entry.first       = 1'b0;
      push.entry.last        = 1'b1;
      push.entry.data_length = 32'sd0;
      if (accept) begin
         case (phase_ff)
            vlpd_pkg::PHASE_DLEN: begin
               if (cont && gc_inc >= vlpd_pkg::MAX_GROUPS) begin
                  push.write_en   = 1'b1;
                  push.entry.kind = vlpd_pkg::KIND_DLEN_LONG;
               end else if (bl_dec == 31'd0) begin
                  // nothing after the data length
                  push.write_en          = 1'b1;
                  push.entry.kind        = vlpd_pkg::KIND_EMPTY;
                  push.entry.first       = 1'b1;
                  push.entry.data_length = dla_next;
               end
            end
            vlpd_pkg::PHASE_PAY: begin
               push.write_en          = 1'b1;
               push.entry.kind        = vlpd_pkg::KIND_PAYLOAD;
               push.entry.data_byte   = req_in_byte;
               push.entry.first       = first_pending_ff;
               push.entry.last        = (bl_dec == 31'd0);
               push.entry.data_length = data_len_accum_ff;
            end
            default: begin
               if (group_count_ff >= vlpd_pkg::MAX_GROUPS) begin
                  push.write_en   = 1'b1;
                  push.entry.kind = vlpd_pkg::KIND_PREFIX_LONG;
               end else if (!cont && len_acc_next[31]) begin
                  push.write_en   = 1'b1;
                  push.entry.kind = vlpd_pkg::KIND_NEGATIVE;
               end else if (!cont && len_acc_next[30:0] == 31'd0) begin
                  push.write_en    = 1'b1;
                  push.entry.kind  = vlpd_pkg::KIND_EMPTY;
                  push.entry.first = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         compression_on_ff <= 1'b0;
         phase_ff          <= vlpd_pkg::PHASE_LEN;
         group_count_ff    <= 3'd0;
         length_accum_ff   <= 32'd0;
         bytes_left_ff     <= 31'd0;
         data_len_accum_ff <= 32'd0;
         first_pending_ff  <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            compression_on_ff <= csr_wr_data;
         end
         phase_ff          <= phase_in;
         group_count_ff    <= group_count_in;
         length_accum_ff   <= length_accum_in;
         bytes_left_ff     <= bytes_left_in;
         data_len_accum_ff <= data_len_accum_in;
         first_pending_ff  <= first_pending_in;
      end
   end

   `VLPD_ASSERT_IMPLIES(a_group_count_bound, 1'b1, group_count_ff <= vlpd_pkg::MAX_GROUPS,
      "group count past five")
   `VLPD_ASSERT_IMPLIES(a_payload_has_bytes, phase_ff == vlpd_pkg::PHASE_PAY,
      bytes_left_ff != 31'd0, "payload phase with no bytes left")

endmodule

@@ rtl/vlpd_queue.sv @@
// short result queue between the decoder and the output stage
`include "varint_length_packet_deframer_core_macros.svh"

module vlpd_queue #(
   parameter int DEPTH = vlpd_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  vlpd_pkg::push_type         push,
   input  logic                       pop,
   output vlpd_pkg::queue_status_type status
);

   localparam int PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountW = $clog2(DEPTH + 1);

   vlpd_pkg::result_type entries_ff [DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0]    count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign do_push = push.write_en;
   assign do_pop  = pop && (count_ff != CountW'(0));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? PtrW'(0) : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? PtrW'(0) : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign status.full      = (count_ff == CountW'(DEPTH));
   assign status.not_empty = (count_ff != CountW'(0));
   assign status.head      = entries_ff[rd_ptr_ff];

   `VLPD_ASSERT_IMPLIES(a_no_push_when_full, push.write_en, count_ff < CountW'(DEPTH),
      "push into a full queue")
   `VLPD_ASSERT_IMPLIES(a_count_bound, 1'b1, count_ff <= CountW'(DEPTH),
      "queue count past depth")
   `VLPD_ASSERT_NEXT(a_count_grows, push.write_en && !do_pop,
      count_ff == $past(count_ff) + CountW'(1), "queue count did not grow on push")

endmodule

@@ rtl/vlpd_emitter.sv @@
// back end: pops queued results into the output register
module vlpd_emitter (
   input  logic                       clock,
   input  logic                       reset,
   input  vlpd_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_kind,
   output logic [7:0]                 rsp_data_byte,
   output logic                       rsp_first,
   output logic                       rsp_last,
   output logic                       rsp_compressed,
   output logic signed [31:0]         rsp_data_length
);

   logic                 rsp_valid_ff, rsp_valid_in;
   vlpd_pkg::result_type out_ff;
   logic                 compressed_ff;
   logic                 load;

   assign load         = !rsp_valid_ff || !rsp_stall;
   assign pop          = load && status.not_empty;
   assign rsp_valid_in = load ? status.not_empty : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff        <= status.head;
         compressed_ff <= (status.head.data_length != 32'sd0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_data_byte   = out_ff.data_byte;
   assign rsp_first       = out_ff.first;
   assign rsp_last        = out_ff.last;
   assign rsp_compressed  = compressed_ff;
   assign rsp_data_length = out_ff.data_length;

endmodule

@@ rtl/varint_length_packet_deframer_core.sv @@
// top level of the varint length-prefixed packet deframer
// The deframer takes one stream byte per cycle and splits the stream into packets framed by a
// 7-bit-group little-endian length prefix of up to five bytes, optionally followed (when
// compression framing is switched on through csr_wr_en/csr_wr_data) by a data-length field
// of up to five bytes. Every payload byte leaves as one item with first and last marks; an
// empty packet leaves one marker item; a too-long prefix, a negative length or a too-long
// data-length field leaves one error item and decoding restarts on the next byte. Bytes are
// taken at a sustained rate of one per cycle while the queue is not full: the decoder updates
// its whole state for each byte, and a result item reaches rsp_* through a short queue and
// then an output register. req_stall rises only when the queue has filled because rsp_stall
// held results back. The user must write the configuration bit only while the block is
// idle; the block itself does not enforce this.
module varint_length_packet_deframer_core #(
   parameter int QUEUE_DEPTH = vlpd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   // input byte channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_first,
   output logic               rsp_last,
   output logic               rsp_compressed,
   output logic signed [31:0] rsp_data_length,
   // compression framing register
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   vlpd_pkg::push_type         push;
   vlpd_pkg::queue_status_type status;
   logic                       pop;

   // stall only on a full queue, never on the result side directly
   assign req_stall = status.full;

   // front: classify each byte and form at most one result item
   vlpd_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .queue_full  (status.full),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   // decoupling queue between the two halves
   vlpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   // back: output register with its own handshake
   vlpd_emitter u_emitter (
      .clock           (clock),
      .reset           (reset),
      .status          (status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_first       (rsp_first),
      .rsp_last        (rsp_last),
      .rsp_compressed  (rsp_compressed),
      .rsp_data_length (rsp_data_length)
   );

endmodule

@@ bench/deframer_checker.sv @@
`timescale 1ns / 100ps
// checker that predicts and compares the deframer results seen on the item channels
module deframer_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [2:0]         rsp_kind,
   input  logic [7:0]         rsp_data_byte,
   input  logic               rsp_first,
   input  logic               rsp_last,
   input  logic               rsp_compressed,
   input  logic signed [31:0] rsp_data_length,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output int                 error_total,
   output int                 results_owed
);

   typedef struct packed {
      vlpd_pkg::kind_type kind;
      logic [7:0]         data_byte;
      logic               first;
      logic               last;
      logic               compressed;
      logic signed [31:0] data_length;
   } deframed_type;

   deframed_type expected_results[$];

   // shadow of the decoder state
   vlpd_pkg::phase_type phase;
   logic [2:0]          group_cnt;
   logic [31:0]         length_acc;
   logic [30:0]         bytes_left;
   logic [31:0]         dlen_acc;
   logic                first_pending;
   logic                compression_on;
   int                  errors = 0;

   initial begin
      error_total  = 0;
      results_owed = 0;
   end

   function automatic void clear_packet();
      phase         = vlpd_pkg::PHASE_LEN;
      group_cnt     = '0;
      length_acc    = '0;
      bytes_left    = '0;
      dlen_acc      = '0;
      first_pending = 1'b1;
   endfunction

   function automatic void add_result(vlpd_pkg::kind_type k, logic [7:0] b, logic f, logic l,
                                      logic [31:0] dl);
      deframed_type r;
      r.kind        = k;
      r.data_byte   = b;
      r.first       = f;
      r.last        = l;
      r.compressed  = (dl != 0);
      r.data_length = dl;
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void add_error(vlpd_pkg::kind_type k);
      clear_packet();
      add_result(k, 8'h00, 1'b0, 1'b1, 32'd0);
   endfunction

   function automatic void add_empty();
      logic [31:0] dl;
      dl = dlen_acc;
      clear_packet();
      add_result(vlpd_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b1, dl);
   endfunction

   function automatic void deframe_byte(logic [7:0] b);
      logic [6:0] grp;
      logic       cont;
      logic       f;
      logic       l;
      grp  = b[6:0];
      cont = b[7];
      case (phase)
         vlpd_pkg::PHASE_DLEN: begin
            dlen_acc |= 32'(grp) << (7 * group_cnt);
            group_cnt++;
            bytes_left--;
            if (cont && group_cnt >= vlpd_pkg::MAX_GROUPS) begin
               add_error(vlpd_pkg::KIND_DLEN_LONG);
            end else if (!(cont && bytes_left != 0)) begin
               // field done, or cut short by the end of the packet
               group_cnt = '0;
               if (bytes_left == 0) add_empty();
               else phase = vlpd_pkg::PHASE_PAY;
            end
         end
         vlpd_pkg::PHASE_PAY: begin
            f             = first_pending;
            first_pending = 1'b0;
            bytes_left--;
            l = (bytes_left == 0);
            add_result(vlpd_pkg::KIND_PAYLOAD, b, f, l, dlen_acc);
            if (l) clear_packet();
         end
         default: begin
            phase = vlpd_pkg::PHASE_LEN;
            if (group_cnt >= vlpd_pkg::MAX_GROUPS) begin
               add_error(vlpd_pkg::KIND_PREFIX_LONG);
            end else begin
               length_acc |= 32'(grp) << (7 * group_cnt);
               group_cnt++;
               if (!cont) begin
                  group_cnt = '0;
                  if (length_acc[31]) begin
                     add_error(vlpd_pkg::KIND_NEGATIVE);
                  end else begin
                     bytes_left    = length_acc[30:0];
                     length_acc    = '0;
                     dlen_acc      = '0;
                     first_pending = 1'b1;
                     if (bytes_left == 0) add_empty();
                     else phase = compression_on ? vlpd_pkg::PHASE_DLEN : vlpd_pkg::PHASE_PAY;
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void check_result();
      deframed_type got;
      deframed_type want;
      got.kind        = vlpd_pkg::kind_type'(rsp_kind);
      got.data_byte   = rsp_data_byte;
      got.first       = rsp_first;
      got.last        = rsp_last;
      got.compressed  = rsp_compressed;
      got.data_length = rsp_data_length;
      if (expected_results.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected result kind %0d byte %02h first %b last %b comp %b %s %0d",
                     $realtime, rsp_kind, got.data_byte, got.first, got.last, got.compressed,
                     "dlen", got.data_length);
      end else begin
         want = expected_results.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: wrong result", $realtime);
               $display("   expected kind %0d byte %02h first %b last %b comp %b dlen %0d",
                        want.kind, want.data_byte, want.first, want.last, want.compressed,
                        want.data_length);
               $display("   actual   kind %0d byte %02h first %b last %b comp %b dlen %0d",
                        rsp_kind, got.data_byte, got.first, got.last, got.compressed,
                        got.data_length);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         compression_on = 1'b0;
         clear_packet();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (csr_wr_en) compression_on = csr_wr_data;
         if (req_valid && !req_stall) deframe_byte(req_in_byte);
      end
      error_total  <= errors;
      results_owed <= expected_results.size();
   end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// stimulus, pacing and verdict for the varint length packet deframer bench
module testbench;

   localparam int ITEMS_PER_RUN = 280;  // random input bytes per run
   localparam int QUIET_LIMIT   = 1000; // cycles with no item moving before giving up
   localparam int HOLD_CYCLES   = 60;   // long receiver hold-off, enough to fill the queue
   localparam int DRAIN_CYCLES  = 8;    // settle time after the last result
   localparam int TAIL_CYCLES   = 16;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_in_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [2:0]         rsp_kind;
   logic [7:0]         rsp_data_byte;
   logic               rsp_first;
   logic               rsp_last;
   logic               rsp_compressed;
   logic signed [31:0] rsp_data_length;
   logic               csr_wr_en   = 1'b0;
   logic               csr_wr_data = 1'b0;

   int   error_total;
   int   results_owed;

   // pacing controls: the sender's own flag is blocking, the receiver's go through nba
   bit   sender_gaps   = 1'b1;
   bit   receiver_gaps = 1'b1;
   bit   hold_pending  = 1'b0;
   int   bytes_sent    = 0;

   // bytes of the packet being built, sent in order
   logic [7:0] stream_q[$];

   varint_length_packet_deframer_core u_top (.*);

   deframer_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random short stalls, plus one long hold-off on request
   initial begin : receiver
      int burst;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending <= 1'b0;
            rsp_stall    <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall    <= 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: ends the run if no item moves on either channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("varint_length_packet_deframer_core: mismatch");
      $finish;
   end

   // one byte onto the input channel, optionally after a short gap
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic flush_stream();
      foreach (stream_q[i]) send_byte(stream_q[i]);
      stream_q.delete();
   endtask

   // stop offering and wait until every predicted result has left the block
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // the register is only touched with the block idle
   task automatic set_compression(input logic on);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic int groups_for(logic [31:0] v);
      int n;
      n = 1;
      while (n < 5 && (v >> (7 * n)) != 0) n++;
      return n;
   endfunction

   // little-endian 7-bit groups; the fifth group carries junk in bits that shift out
   function automatic void push_varint(ref logic [7:0] q[$], input logic [31:0] v,
                                       input int ngroups);
      logic [6:0] grp;
      for (int i = 0; i < ngroups; i++) begin
         grp = 7'(v >> (7 * i));
         if (i == 4) grp = {3'($urandom), v[31:28]};
         q.insert(q.size(), {i < ngroups - 1, grp});
      end
   endfunction

   // well-formed packet with random content, sometimes padded or cut inside data length
   function automatic void make_packet(input logic comp);
      logic [7:0]  body[$];
      logic [31:0] dval;
      int          dgroups;
      int          n_data;
      int          len;
      int          lgroups;
      dgroups = 0;
      if (comp) begin
         case ($urandom_range(0, 3))
            0, 1:    dval = 32'd0;
            2:       dval = $urandom_range(1, 400);
            default: dval = $urandom;
         endcase
         dgroups = groups_for(dval);
         if ($urandom_range(0, 4) == 0) dgroups = $urandom_range(dgroups, 5);
         push_varint(body, dval, dgroups);
      end
      n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 140) : $urandom_range(0, 8);
      repeat (n_data) body.insert(body.size(), 8'($urandom));
      len = body.size();
      // packet ending part way through the data-length field
      if (comp && $urandom_range(0, 9) == 0) len = $urandom_range(1, dgroups);
      if ($urandom_range(0, 15) == 0) len = 0;
      lgroups = groups_for(len);
      if ($urandom_range(0, 4) == 0) lgroups = $urandom_range(lgroups, 5);
      push_varint(stream_q, len, lgroups);
      for (int i = 0; i < len; i++) stream_q.insert(stream_q.size(), body[i]);
   endfunction

   // broken framing with random content; each one leaves the decoder at a new prefix
   function automatic void make_broken(input logic comp);
      case ($urandom_range(0, comp ? 2 : 1))
         0: begin
            // prefix running to a sixth byte
            repeat (5) stream_q.insert(stream_q.size(), {1'b1, 7'($urandom)});
            stream_q.insert(stream_q.size(), 8'($urandom));
         end
         1: begin
            // five-byte prefix with bit 31 set
            repeat (4) stream_q.insert(stream_q.size(), {1'b1, 7'($urandom)});
            stream_q.insert(stream_q.size(), {1'b0, 3'($urandom), 1'b1, 3'($urandom)});
         end
         default: begin
            // data-length field that never ends
            push_varint(stream_q, $urandom_range(6, 40), 1);
            repeat (5) stream_q.insert(stream_q.size(), {1'b1, 7'($urandom)});
         end
      endcase
   endfunction

   task automatic run_random(input logic comp, input int count, input bit quiet_tail);
      int target;
      target = bytes_sent + count;
      while (bytes_sent < target) begin
         // idling switched per packet, so some stretches run flat out
         sender_gaps   = !quiet_tail && ($urandom_range(0, 3) != 0);
         receiver_gaps <= !quiet_tail && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) make_broken(comp);
         else make_packet(comp);
         flush_stream();
         // occasional full drain mid-phase
         if (!quiet_tail && $urandom_range(0, 39) == 0) wait_drained();
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_compression(1'b0);
      // plain framing: empty packet, one-byte packet with all ones, a prefix that
      // runs to a sixth byte, and a negative length
      stream_q = '{8'h00,
                   8'h01, 8'hFF,
                   8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7F,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
      flush_stream();

      set_compression(1'b1);
      // compression framing: two-group data length then payload, a data length
      // that never ends, one cut short by the packet end, and one with no payload
      stream_q = '{8'h03, 8'h85, 8'h01, 8'hAA,
                   8'h06, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                   8'h02, 8'h81, 8'h81,
                   8'h01, 8'h07};
      flush_stream();

      set_compression(1'b0);
      run_random(1'b0, ITEMS_PER_RUN, 1'b0);

      // long receiver hold-off while the sender keeps offering
      set_compression(1'b1);
      hold_pending <= 1'b1;
      run_random(1'b1, ITEMS_PER_RUN, 1'b0);

      set_compression(1'b0);
      run_random(1'b0, ITEMS_PER_RUN, 1'b0);

      // closing stretch with no idling on either side
      set_compression(1'b1);
      run_random(1'b1, ITEMS_PER_RUN, 1'b1);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_total == 0 && results_owed == 0)
         $display("varint_length_packet_deframer_core: match");
      else
         $display("varint_length_packet_deframer_core: mismatch");
      $finish;
   end

endmodule

@@ varint_length_packet_deframer_core.f @@
+incdir+rtl
rtl/vlpd_pkg.sv
rtl/vlpd_decoder.sv
rtl/vlpd_queue.sv
rtl/vlpd_emitter.sv
rtl/varint_length_packet_deframer_core.sv
bench/deframer_checker.sv
bench/testbench.sv
